>>> sv/scsa_pkg.sv
// Shared types and constants for the sparse convolution scatter-accumulate block.
package scsa_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 6;
	localparam int LinW     = 18;

	localparam logic [CfgIdxW-1:0] CFG_SIZE_X = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SIZE_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SIZE_Z = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_FILT_X = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_FILT_Y = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_FILT_Z = 3'd5;

	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [4:0]         pos_x;
		logic [4:0]         pos_y;
		logic [4:0]         pos_z;
		logic [4:0]         tap_x;
		logic [4:0]         tap_y;
		logic [4:0]         tap_z;
		logic signed [15:0] sample;
		logic signed [15:0] weight;
		logic [14:0]        read_index;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic [14:0]        entry_index;
		logic signed [47:0] entry_value;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic map_en;
		logic tsum_en;
		logic lin_en;
		logic ram_rd;
		logic commit;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_busy;
		logic is_read;
		logic map_hit;
		logic rd_oob;
		logic out_free;
	} ctrl_stat_t;

endpackage

>>> sv/sparse_conv_scatter_accumulate_top.sv
// Top level of the sparse 3-D convolution scatter-accumulate block.
// One item is in flight at a time. An accumulate item passes the coordinate
// map, two dependent index multiplies, store read, saturating add and
// write-back before the next acceptance; a dropped pair skips the store read
// and write-back, a read-and-clear item the index multiplies. The pace is set
// by the index multiply chain and the read-modify-write of the single store
// RAM. A finished result waits in the output register, and a new item is
// taken once the previous result has moved into it. After reset the store is
// cleared one entry per cycle, all AXIS_MAX**3 entries (32768 at the default),
// while input stays stalled; configuration writes are taken throughout.
module sparse_conv_scatter_accumulate_top
	import scsa_pkg::*;
#(
	parameter int AXIS_MAX  = 32,
	parameter int ACC_WIDTH = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	scsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	scsa_dpath #(
		.AXIS_MAX  (AXIS_MAX),
		.ACC_WIDTH (ACC_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		stat.clear_busy |-> in_stall)
		else $error("item accepted during store clear");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item accepted while one is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> (out_data.entry_value == '0))
		else $error("miss result carries a nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.finish) |-> !stat.clear_busy)
		else $error("result produced during store clear");

endmodule

>>> sv/scsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scsa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/scsa_ctrl.sv
// Sequencing state machine for the scatter-accumulate block.
module scsa_ctrl
	import scsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_TSUM,
		ST_LIN,
		ST_READ,
		ST_COMMIT,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE) || stat.clear_busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.map_en  = (state_q == ST_MAP);
		cmd.tsum_en = (state_q == ST_TSUM);
		cmd.lin_en  = (state_q == ST_LIN);
		cmd.ram_rd  = (state_q == ST_READ) && !(stat.is_read && stat.rd_oob);
		cmd.commit  = (state_q == ST_COMMIT) && stat.out_free;
		cmd.finish  = (state_q == ST_FINISH) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_valid ? ST_MAP : ST_IDLE;
					end
				end
				ST_MAP:  state_q <= stat.is_read ? ST_READ : ST_TSUM;
				ST_TSUM: state_q <= ST_LIN;
				ST_LIN:  state_q <= stat.map_hit ? ST_READ : ST_FINISH;
				ST_READ: state_q <= (stat.is_read && stat.rd_oob) ? ST_FINISH : ST_COMMIT;
				ST_COMMIT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FINISH: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sv/scsa_dpath.sv
// Datapath: coordinate mapping, linear index, product, store and result register.
module scsa_dpath
	import scsa_pkg::*;
#(
	parameter int AXIS_MAX  = 32,
	parameter int ACC_WIDTH = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  in_item_t            in_data,
	input  logic                out_stall,
	output logic                out_valid,
	output out_item_t           out_data,
	input  ctrl_cmd_t           cmd,
	output ctrl_stat_t          stat
);

	localparam int DEPTH = AXIS_MAX * AXIS_MAX * AXIS_MAX;
	localparam int IDX_W = $clog2(DEPTH);

	function automatic logic signed [6:0] axis_coord(logic [4:0] pos, logic [4:0] tap,
		logic [4:0] filt);
		logic [3:0] off;
		off = (filt == 5'd0) ? 4'd0 : 4'((filt - 5'd1) >> 1);
		return $signed({2'b00, pos}) - $signed({2'b00, tap}) + $signed({3'b000, off});
	endfunction

	function automatic logic [5:0] clamp_size(logic [5:0] s);
		return (32'(s) > AXIS_MAX) ? 6'(AXIS_MAX) : s;
	endfunction

	logic [5:0] size_x_q, size_y_q, size_z_q;
	logic [4:0] filt_x_q, filt_y_q, filt_z_q;
	logic [5:0] sx, sy, sz;

	in_item_t           item_q;
	logic [5:0]         cx_q, cy_q, cz_q;
	logic               map_hit_q;
	logic signed [31:0] prod_q;
	logic [12:0]        t_q;
	logic [LinW-1:0]    lin_q;
	logic [IDX_W:0]     clr_cnt_q;
	logic               clear_busy;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [6:0] ax, ay, az;
	logic              hx, hy, hz;
	logic [IDX_W-1:0]  addr;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ACC_WIDTH-1:0] ram_wdata;
	logic [ACC_WIDTH-1:0] rdata;
	logic signed [ACC_WIDTH-1:0] acc_old;
	logic signed [ACC_WIDTH:0]   sum_w;
	logic signed [ACC_WIDTH-1:0] acc_new;
	logic signed [63:0]          val_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 6'd32;
			size_y_q <= 6'd32;
			size_z_q <= 6'd32;
			filt_x_q <= 5'd3;
			filt_y_q <= 5'd3;
			filt_z_q <= 5'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE_X: size_x_q <= cfg_data;
				CFG_SIZE_Y: size_y_q <= cfg_data;
				CFG_SIZE_Z: size_z_q <= cfg_data;
				CFG_FILT_X: filt_x_q <= cfg_data[4:0];
				CFG_FILT_Y: filt_y_q <= cfg_data[4:0];
				CFG_FILT_Z: filt_z_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign sx = clamp_size(size_x_q);
	assign sy = clamp_size(size_y_q);
	assign sz = clamp_size(size_z_q);

	assign ax = axis_coord(item_q.pos_x, item_q.tap_x, filt_x_q);
	assign ay = axis_coord(item_q.pos_y, item_q.tap_y, filt_y_q);
	assign az = axis_coord(item_q.pos_z, item_q.tap_z, filt_z_q);
	assign hx = !ax[6] && (ax[5:0] < sx);
	assign hy = !ay[6] && (ay[5:0] < sy);
	assign hz = !az[6] && (az[5:0] < sz);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.map_en) begin
			cx_q      <= ax[5:0];
			cy_q      <= ay[5:0];
			cz_q      <= az[5:0];
			map_hit_q <= hx && hy && hz;
			prod_q    <= item_q.sample * item_q.weight;
		end
		if (cmd.tsum_en) begin
			t_q <= 13'(cy_q) + 13'(sy) * 13'(cz_q);
		end
		if (cmd.lin_en) begin
			lin_q <= LinW'(cx_q) + LinW'(sx) * LinW'(t_q);
		end
	end

	// clearing pass over the whole store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clear_busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign clear_busy = (clr_cnt_q != (IDX_W+1)'(DEPTH));

	assign addr = (item_q.cmd == CMD_READ) ? IDX_W'(item_q.read_index) : IDX_W'(lin_q);

	assign acc_old = $signed(rdata);
	assign sum_w   = (ACC_WIDTH+1)'(acc_old) + (ACC_WIDTH+1)'(prod_q);
	always_comb begin
		if (sum_w[ACC_WIDTH] != sum_w[ACC_WIDTH-1]) begin
			acc_new = sum_w[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
			                           : {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			acc_new = sum_w[ACC_WIDTH-1:0];
		end
	end
	assign val_w = 64'((item_q.cmd == CMD_READ) ? acc_old : acc_new);

	assign ram_we    = clear_busy || cmd.commit;
	assign ram_waddr = clear_busy ? clr_cnt_q[IDX_W-1:0] : addr;
	assign ram_wdata = (clear_busy || item_q.cmd == CMD_READ) ? '0 : acc_new;

	scsa_ram #(
		.WIDTH(ACC_WIDTH),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.ram_rd),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.hit         <= 1'b1;
			out_q.entry_index <= (item_q.cmd == CMD_READ) ? item_q.read_index : 15'(lin_q);
			out_q.entry_value <= val_w[47:0];
		end else if (cmd.finish) begin
			out_q.hit         <= 1'b0;
			out_q.entry_index <= (item_q.cmd == CMD_READ) ? item_q.read_index : 15'd0;
			out_q.entry_value <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.clear_busy = clear_busy;
	assign stat.is_read    = (item_q.cmd == CMD_READ);
	assign stat.map_hit    = map_hit_q;
	assign stat.rd_oob     = (32'(item_q.read_index) >= DEPTH);
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule
